### sv/ptia_pkg.sv
// Shared constants for the point-in-triangle area test.
package ptia_pkg;

  localparam int DIFF_W      = 36;   // area difference output width
  localparam int THRESH_W    = 35;   // threshold register width
  localparam int SQRT_SHIFT  = 16;   // squared length bits dropped before root
  localparam int AREA_FIXED  = 7;    // area stages besides the root stages
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(256);

endpackage

### sv/ptia_if.sv
// Channel interfaces: query input, result output, threshold write.
interface ptia_in_if #(parameter int COORD_WIDTH = 20);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] a_light, a_redgreen, a_yellowblue;
  logic signed [COORD_WIDTH-1:0] b_light, b_redgreen, b_yellowblue;
  logic signed [COORD_WIDTH-1:0] c_light, c_redgreen, c_yellowblue;
  logic signed [COORD_WIDTH-1:0] p_light, p_redgreen, p_yellowblue;
  modport source (output valid, a_light, a_redgreen, a_yellowblue, b_light, b_redgreen,
                  b_yellowblue, c_light, c_redgreen, c_yellowblue, p_light, p_redgreen,
                  p_yellowblue, input ready);
  modport sink (input valid, a_light, a_redgreen, a_yellowblue, b_light, b_redgreen,
                b_yellowblue, c_light, c_redgreen, c_yellowblue, p_light, p_redgreen,
                p_yellowblue, output ready);
endinterface

interface ptia_out_if;
  logic               valid;
  logic               ready;
  logic               in_triangle;
  logic signed [35:0] area_difference;
  modport source (output valid, in_triangle, area_difference, input ready);
  modport sink (input valid, in_triangle, area_difference, output ready);
endinterface

interface ptia_cfg_if;
  logic        valid;
  logic        ready;
  logic [34:0] inside_threshold;
  modport source (output valid, inside_threshold, input ready);
  modport sink (input valid, inside_threshold, output ready);
endinterface

### sv/ptia_area.sv
// Pipelined triangle area: edges, cross product, squared length, bit-serial root.
module ptia_area import ptia_pkg::*; #(
  parameter int CW = 20
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [CW-1:0]  a_i [3],
  input  logic signed [CW-1:0]  b_i [3],
  input  logic signed [CW-1:0]  c_i [3],
  output logic [2*CW-7:0]       area_o
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int MW  = 2 * CW + 1;
  localparam int H   = (MW + 1) / 2;
  localparam int HW  = MW - H;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int TW  = SW - SQRT_SHIFT;
  localparam int R   = TW / 2;
  localparam int RW  = R + 2;

  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic signed [PW-1:0] p_q [6];
  logic signed [PW:0]   k_d [3];
  logic [MW-1:0]        m_d [3];
  logic [MW-1:0]        m_q [3];
  logic [2*HW-1:0]      hh_q [3];
  logic [MW-1:0]        hl_q [3];
  logic [2*H-1:0]       ll_q [3];
  logic [SQW-1:0]       sq_q [3];
  logic [SW-1:0]        s_q;
  logic [R-1:0]         root_q [R];
  logic [RW-1:0]        rem_q [R];
  logic [TW-1:0]        rad_q [R];
  logic [R:0]           rnd;
  logic [R-1:0]         area_q;

  // edge vectors
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= DW'(b_i[i]) - DW'(a_i[i]);
        v_q[i] <= DW'(c_i[i]) - DW'(a_i[i]);
      end
    end
  end

  // cross-product partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= u_q[1] * v_q[2];
      p_q[1] <= v_q[1] * u_q[2];
      p_q[2] <= u_q[2] * v_q[0];
      p_q[3] <= v_q[2] * u_q[0];
      p_q[4] <= u_q[0] * v_q[1];
      p_q[5] <= v_q[0] * u_q[1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_d[i] = (PW+1)'(p_q[2*i]) - (PW+1)'(p_q[2*i+1]);
      m_d[i] = k_d[i][PW] ? MW'(-k_d[i]) : MW'(k_d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i]  <= m_d[i];
        hh_q[i] <= (2*HW)'(m_q[i][MW-1:H]) * (2*HW)'(m_q[i][MW-1:H]);
        hl_q[i] <= MW'(m_q[i][MW-1:H]) * MW'(m_q[i][H-1:0]);
        ll_q[i] <= (2*H)'(m_q[i][H-1:0]) * (2*H)'(m_q[i][H-1:0]);
        sq_q[i] <= {hh_q[i], (2*H)'(0)} + (SQW'(hl_q[i]) << (H + 1)) + SQW'(ll_q[i]);
      end
      s_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    end
  end

  // restoring square root, one result bit per stage
  for (genvar j = 0; j < R; j++) begin : g_root
    logic [TW-1:0] rad_in;
    logic [RW-1:0] rem_in;
    logic [R-1:0]  root_in;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    if (j == 0) begin : g_first
      assign rad_in  = s_q[SW-1:SQRT_SHIFT];
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end
    assign cur   = {rem_in[RW-3:0], rad_in[TW-1-2*j -: 2]};
    assign trial = {root_in, 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j] <= rad_in;
        if (cur >= trial) begin
          rem_q[j]  <= cur - trial;
          root_q[j] <= {root_in[R-2:0], 1'b1};
        end else begin
          rem_q[j]  <= cur;
          root_q[j] <= {root_in[R-2:0], 1'b0};
        end
      end
    end
  end

  // halve with round half up
  assign rnd = {1'b0, root_q[R-1]} + (R+1)'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      area_q <= rnd[R:1];
    end
  end

  assign area_o = area_q;

endmodule

### sv/point_in_triangle_area_test_top.sv
// Top level of the point-in-triangle area-sum test.
//
//  channel | dir | payload                              | accepted when
//  in_i    | in  | A, B, C, P: 12 signed coordinates     | valid & ready
//  out_o   | out | in_triangle, area_difference (36 b)  | valid & ready
//  cfg_i   | in  | inside_threshold (35 b)              | valid & ready
//
// One transaction per cycle while out_o does not stall the pipeline; the four
// area units take their square roots bit-serially, one result bit per stage.
// Reset clears the valid bits and loads the threshold with 1.0 (256).
// The whole pipeline advances together; it holds only while a result sits
// in the output register unaccepted, so in_i stays ready while out_o drains.
module point_in_triangle_area_test_top import ptia_pkg::*; #(
  parameter int COORD_WIDTH = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptia_in_if.sink    in_i,
  ptia_out_if.source out_o,
  ptia_cfg_if.sink   cfg_i
);

  localparam int AW  = 2 * COORD_WIDTH - 6;           // area width
  localparam int EW  = (2 * COORD_WIDTH - 3 > 37) ? 2 * COORD_WIDTH - 3 : 37;
  localparam int LAT = AW + AREA_FIXED + 2;           // valid stages
  localparam logic signed [EW-1:0] DIFF_HI =
    {{(EW-DIFF_W+1){1'b0}}, {(DIFF_W-1){1'b1}}};
  localparam logic signed [EW-1:0] DIFF_LO =
    {{(EW-DIFF_W+1){1'b1}}, {(DIFF_W-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] va [3];
  logic signed [COORD_WIDTH-1:0] vb [3];
  logic signed [COORD_WIDTH-1:0] vc [3];
  logic signed [COORD_WIDTH-1:0] vp [3];
  logic [AW-1:0]        area [4];
  logic                 en;
  logic [LAT-1:0]       vld_q;
  logic [THRESH_W-1:0]  thresh_q;
  logic signed [EW-1:0] diff_q;
  logic signed [EW-1:0] thr_ext;
  logic signed [EW-1:0] sat;
  logic                 flag_q;
  logic [DIFF_W-1:0]    res_q;

  assign va = '{in_i.a_light, in_i.a_redgreen, in_i.a_yellowblue};
  assign vb = '{in_i.b_light, in_i.b_redgreen, in_i.b_yellowblue};
  assign vc = '{in_i.c_light, in_i.c_redgreen, in_i.c_yellowblue};
  assign vp = '{in_i.p_light, in_i.p_redgreen, in_i.p_yellowblue};

  // global advance: stop only when the output register holds an untaken result
  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // threshold register, writable any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.inside_threshold;
    end
  end

  // sub-triangles PBC, APC, ABP and the triangle ABC
  ptia_area #(.CW(COORD_WIDTH)) u_area_pbc (
    .clk_i, .en_i(en), .a_i(vp), .b_i(vb), .c_i(vc), .area_o(area[0]));
  ptia_area #(.CW(COORD_WIDTH)) u_area_apc (
    .clk_i, .en_i(en), .a_i(va), .b_i(vp), .c_i(vc), .area_o(area[1]));
  ptia_area #(.CW(COORD_WIDTH)) u_area_abp (
    .clk_i, .en_i(en), .a_i(va), .b_i(vb), .c_i(vp), .area_o(area[2]));
  ptia_area #(.CW(COORD_WIDTH)) u_area_abc (
    .clk_i, .en_i(en), .a_i(va), .b_i(vb), .c_i(vc), .area_o(area[3]));

  assign thr_ext = EW'(thresh_q);

  always_comb begin
    sat = diff_q;
    if (diff_q > DIFF_HI) begin
      sat = DIFF_HI;
    end else if (diff_q < DIFF_LO) begin
      sat = DIFF_LO;
    end
  end

  // difference, then flag and saturation into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= EW'(area[0]) + EW'(area[1]) + EW'(area[2]) - EW'(area[3]);
      flag_q <= diff_q < thr_ext;
      res_q  <= sat[DIFF_W-1:0];
    end
  end

  assign out_o.valid           = vld_q[LAT-1];
  assign out_o.in_triangle     = flag_q;
  assign out_o.area_difference = res_q;

endmodule

### sv/ptia_checker.sv
// Port-level checks for the area test, bound to the top level.
module ptia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_flag,
  input logic [35:0] out_diff
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_diff) && $stable(out_flag))
    else $error("result changed while stalled");

  // threshold is never negative, so a negative difference is inside
  a_neg_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_diff[35] |-> out_flag)
    else $error("negative difference not flagged inside");

  // input never blocked while the output register is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  // input blocked whenever the output stalls
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

endmodule

bind point_in_triangle_area_test_top ptia_checker u_ptia_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_flag  (out_o.in_triangle),
  .out_diff  (out_o.area_difference)
);

### tb/tb_point_in_triangle_area_test_top.sv
// Testbench for the point-in-triangle area-sum block: exact-arithmetic predictor and checker.
`timescale 1ns / 1ps
module tb_point_in_triangle_area_test_top import ptia_pkg::*;;

  localparam int CW      = 20;
  localparam int LATENCY = 2 * CW + 3;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t al, ar, ay, bl, br, by, cl, cr, cy, pl, pr, py;
  } query_t;
  typedef struct packed {
    logic                      in_tri;
    logic signed [DIFF_W-1:0]  diff;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptia_in_if #(.COORD_WIDTH(CW)) in_if ();
  ptia_out_if out_if ();
  ptia_cfg_if cfg_if ();

  point_in_triangle_area_test_top #(.COORD_WIDTH(CW)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Threshold as the block currently holds it; only changed while idle.
  logic [THRESH_W-1:0] threshold_q = THRESH_RST;

  query_t   query_queue[$];
  verdict_t verdict_queue[$];
  int       n_failures = 0;
  longint   n_cycles   = 0;
  bit       driving_enabled = 1'b0;
  bit       calm_in = 1'b0;
  bit       calm_out = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Exact area at 8 fractional bits: round-half-up of sqrt(S)/2 via isqrt(S >> 16).
  function automatic logic [63:0] area_of(longint a[3], longint b[3], longint c[3]);
    logic signed [127:0] u[3], v[3], k0, k1, k2;
    logic [127:0] s, t, root, cand;
    for (int i = 0; i < 3; i++) begin
      u[i] = b[i] - a[i];
      v[i] = c[i] - a[i];
    end
    k0 = u[1] * v[2] - v[1] * u[2];
    k1 = u[2] * v[0] - v[2] * u[0];
    k2 = u[0] * v[1] - v[0] * u[1];
    s = k0 * k0 + k1 * k1 + k2 * k2;
    t = s >> SQRT_SHIFT;
    root = '0;
    for (int bitpos = 62; bitpos >= 0; bitpos--) begin
      cand = root | (128'd1 << bitpos);
      if (cand * cand <= t) root = cand;
    end
    return 64'((root + 1) >> 1);
  endfunction

  function automatic verdict_t judge_point(query_t q);
    longint va[3], vb[3], vc[3], vp[3];
    longint d, hi, lo;
    verdict_t r;
    va = '{q.al, q.ar, q.ay};
    vb = '{q.bl, q.br, q.by};
    vc = '{q.cl, q.cr, q.cy};
    vp = '{q.pl, q.pr, q.py};
    d = longint'(area_of(vp, vb, vc)) + longint'(area_of(va, vp, vc))
      + longint'(area_of(va, vb, vp)) - longint'(area_of(va, vb, vc));
    r.in_tri = d < longint'({29'd0, threshold_q});
    hi = (64'sd1 <<< (DIFF_W - 1)) - 1;
    lo = -(64'sd1 <<< (DIFF_W - 1));
    if (d > hi) d = hi;
    if (d < lo) d = lo;
    r.diff = d[DIFF_W-1:0];
    return r;
  endfunction

  function automatic coord_t rand_coord(int span);
    case ($urandom_range(0, 9))
      0: return coord_t'(20'sh80000);
      1: return coord_t'(20'sh7ffff);
      2, 3: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Well-formed case: P usually built as a barycentric mix of A, B, C (inside or near), else random.
  function automatic query_t make_query();
    query_t q;
    int span, wa, wb, wc;
    span = ($urandom_range(0, 3) == 0) ? 524287 : $urandom_range(1, 4096);
    q.al = rand_coord(span); q.ar = rand_coord(span); q.ay = rand_coord(span);
    q.bl = rand_coord(span); q.br = rand_coord(span); q.by = rand_coord(span);
    q.cl = rand_coord(span); q.cr = rand_coord(span); q.cy = rand_coord(span);
    if ($urandom_range(0, 2) != 0) begin
      wa = $urandom_range(0, 256); wb = $urandom_range(0, 256 - wa); wc = 256 - wa - wb;
      q.pl = coord_t'((longint'(q.al) * wa + longint'(q.bl) * wb + longint'(q.cl) * wc) / 256);
      q.pr = coord_t'((longint'(q.ar) * wa + longint'(q.br) * wb + longint'(q.cr) * wc) / 256);
      q.py = coord_t'((longint'(q.ay) * wa + longint'(q.by) * wb + longint'(q.cy) * wc) / 256);
    end else begin
      q.pl = rand_coord(span); q.pr = rand_coord(span); q.py = rand_coord(span);
    end
    return q;
  endfunction

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      {in_if.a_light, in_if.a_redgreen, in_if.a_yellowblue, in_if.b_light, in_if.b_redgreen,
       in_if.b_yellowblue, in_if.c_light, in_if.c_redgreen, in_if.c_yellowblue,
       in_if.p_light, in_if.p_redgreen, in_if.p_yellowblue} <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) verdict_queue.push_back(judge_point(query_queue.pop_front()));
      if (driving_enabled && query_queue.size() > 0 && (calm_in || $urandom_range(0, 99) >= 8))
      begin
        in_if.valid <= 1'b1;
        {in_if.a_light, in_if.a_redgreen, in_if.a_yellowblue, in_if.b_light, in_if.b_redgreen,
         in_if.b_yellowblue, in_if.c_light, in_if.c_redgreen, in_if.c_yellowblue,
         in_if.p_light, in_if.p_redgreen, in_if.p_yellowblue} <= query_queue[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor and output back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      n_cycles <= n_cycles + 1;
      if (out_if.valid && out_if.ready) begin
        if (verdict_queue.size() == 0) begin
          $error("unexpected result transaction");
          n_failures++;
        end else begin
          want = verdict_queue.pop_front();
          if (out_if.in_triangle !== want.in_tri) begin
            $error("in_triangle: expected %0b, got %0b", want.in_tri, out_if.in_triangle);
            n_failures++;
          end
          if (out_if.area_difference !== want.diff) begin
            $error("area_difference: expected %0d, got %0d", want.diff,
                   out_if.area_difference);
            n_failures++;
          end
        end
      end
      out_if.ready <= calm_out || $urandom_range(0, 99) >= 8;
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic set_threshold(logic [THRESH_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.inside_threshold <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    threshold_q = value;
  endtask

  // Wait for every expectation to drain, then let the pipeline empty.
  task automatic drain();
    wait (query_queue.size() == 0 && !in_if.valid && verdict_queue.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) query_queue.push_back(make_query());
    driving_enabled = 1'b1;
    drain();
  endtask

  initial begin
    query_t q;
    cfg_if.valid = 1'b0;
    cfg_if.inside_threshold = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, degenerate triangles, point on a vertex, wrap-around spans.
    q = '0; query_queue.push_back(q);                          // all coincident
    q = '1; query_queue.push_back(q);                          // all -1 lsb
    q = {12{20'sh7ffff}}; query_queue.push_back(q);
    q = {12{20'sh80000}}; query_queue.push_back(q);
    q = '0; q.bl = 20'sh7ffff; q.cr = 20'sh7ffff; query_queue.push_back(q);   // P on A
    q = '0; q.bl = 20'sh00100; q.cl = 20'sh00200; q.pl = 20'sh00080;
    query_queue.push_back(q);                                  // collinear
    q = '0; q.bl = 20'sh00100; q.cr = 20'sh00100; q.pl = 20'sh00040; q.pr = 20'sh00040;
    query_queue.push_back(q);                                  // small inside
    q.pl = 20'sh00200; q.pr = 20'sh00200; query_queue.push_back(q);   // small outside
    q.py = 20'sh00001; query_queue.push_back(q);               // tiny offset, rounding
    // Huge spread: maximum magnitude differences.
    q = {20'sh80000, 20'sh80000, 20'sh80000, 20'sh7ffff, 20'sh80000, 20'sh80000,
         20'sh80000, 20'sh7ffff, 20'sh80000, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff};
    query_queue.push_back(q);
    q.py = 20'sh80000; query_queue.push_back(q);
    q = {20'sh7ffff, 20'sh7ffff, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh7ffff,
         20'sh7ffff, 20'sh80000, 20'sh7ffff, 20'sh80000, 20'sh7ffff, 20'sh80000};
    query_queue.push_back(q);
    for (int i = 0; i < 8; i++) query_queue.push_back(make_query());
    driving_enabled = 1'b1;
    drain();

    // Random phases across thresholds, extremes included.
    set_threshold('0);
    run_phase(150);
    set_threshold('1);
    run_phase(150);
    set_threshold(THRESH_W'(1));
    calm_in = 1'b1; calm_out = 1'b1;                           // no idling stretch
    run_phase(150);
    calm_in = 1'b0; calm_out = 1'b0;
    set_threshold(THRESH_W'($urandom_range(0, 65535)));
    run_phase(200);
    set_threshold(THRESH_RST);
    run_phase(180);

    if (n_failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
sv/ptia_pkg.sv
sv/ptia_if.sv
sv/ptia_area.sv
sv/point_in_triangle_area_test_top.sv
sv/ptia_checker.sv
tb/tb_point_in_triangle_area_test_top.sv
